### sv/assert_macros.svh
// Assertion macros used by the dock clean cycle sequencer RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clk edge, skipped while rst_n is low.
`define DCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising clk edge, also during reset.
`define DCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DCS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/dcs_pkg.sv
// Types, codes and reset constants of the dock clean cycle sequencer.
// No dependencies; used by dcs_step and the top level.
`default_nettype none

package dcs_pkg;

  localparam int unsigned ApbAw = 5;
  localparam int unsigned ApbDw = 32;

  typedef enum logic [3:0] {
    PH_INIT    = 4'd0,
    PH_ADD_S   = 4'd1,
    PH_ADD_W   = 4'd2,
    PH_DRAIN_S = 4'd3,
    PH_DRAIN_W = 4'd4,
    PH_CLEAN_S = 4'd5,
    PH_CLEAN_W = 4'd6,
    PH_FINISH  = 4'd7,
    PH_FAILED  = 4'd8,
    PH_END     = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    REQ_NONE        = 3'd0,
    REQ_ADD_START   = 3'd1,
    REQ_ADD_STOP    = 3'd2,
    REQ_DRAIN_START = 3'd3,
    REQ_DRAIN_STOP  = 3'd4,
    REQ_CLEAN_START = 3'd5,
    REQ_CLEAN_STOP  = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    VALVE_KEEP  = 2'd0,
    VALVE_OPEN  = 2'd1,
    VALVE_CLOSE = 2'd2
  } valve_e;

  typedef enum logic [2:0] {
    REG_ADD_TIMEOUT   = 3'd0,
    REG_DRAIN_TIMEOUT = 3'd1,
    REG_CLEAN_TICKS   = 3'd2,
    REG_HB_LIMIT      = 3'd3,
    REG_BATT_LOW      = 3'd4,
    REG_BATT_FULL     = 3'd5
  } reg_e;

  localparam logic [15:0] AddTimeoutRst   = 16'd600;
  localparam logic [15:0] DrainTimeoutRst = 16'd600;
  localparam logic [7:0]  CleanTicksRst   = 8'd15;
  localparam logic [7:0]  HbLimitRst      = 8'd5;
  localparam logic [9:0]  BattLowRst      = 10'd200;
  localparam logic [9:0]  BattFullRst     = 10'd995;

  typedef struct packed {
    logic [15:0] add_timeout_ticks;
    logic [15:0] drain_timeout_ticks;
    logic [7:0]  clean_ticks;
    logic [7:0]  heartbeat_limit;
    logic [9:0]  battery_low_permille;
    logic [9:0]  battery_full_permille;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] add_count;
    logic [15:0] drain_count;
    logic [7:0]  clean_count;
    logic [7:0]  prev_heartbeat;
    logic [7:0]  stale_count;
    logic        contact_prev;
    logic        contact_now;
  } state_t;

  typedef struct packed {
    logic       sync_ok;
    logic [7:0] heartbeat;
    logic       electrode_down;
    logic       charging;
    logic       charge_paused;
    logic [9:0] battery_permille;
    logic       clean_water_high;
    logic       sewage_low;
    logic       tank_full;
    logic       emergency;
    logic       service_ok;
  } item_t;

  typedef struct packed {
    phase_e cycle_state;
    req_e   service_request;
    valve_e valve_action;
    logic   pause_pulse;
    logic   motor_enable_pulse;
    logic   battery_update_pulse;
  } result_t;

endpackage

`default_nettype wire

### sv/dcs_ifs.sv
// Item channel interfaces of the dock clean cycle sequencer.
// Plain valid/ready channels; no package dependency.
`default_nettype none

interface dcs_in_if;
  logic       valid;
  logic       ready;
  logic       sync_ok;
  logic [7:0] heartbeat;
  logic       electrode_down;
  logic       charging;
  logic       charge_paused;
  logic [9:0] battery_permille;
  logic       clean_water_high;
  logic       sewage_low;
  logic       tank_full;
  logic       emergency;
  logic       service_ok;

  modport source (
    output valid, sync_ok, heartbeat, electrode_down, charging, charge_paused,
           battery_permille, clean_water_high, sewage_low, tank_full, emergency,
           service_ok,
    input  ready
  );
  modport sink (
    input  valid, sync_ok, heartbeat, electrode_down, charging, charge_paused,
           battery_permille, clean_water_high, sewage_low, tank_full, emergency,
           service_ok,
    output ready
  );
endinterface

interface dcs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cycle_state;
  logic [2:0] service_request;
  logic [1:0] valve_action;
  logic       pause_pulse;
  logic       motor_enable_pulse;
  logic       battery_update_pulse;

  modport source (
    output valid, cycle_state, service_request, valve_action, pause_pulse,
           motor_enable_pulse, battery_update_pulse,
    input  ready
  );
  modport sink (
    input  valid, cycle_state, service_request, valve_action, pause_pulse,
           motor_enable_pulse, battery_update_pulse,
    output ready
  );
endinterface

`default_nettype wire

### sv/dock_clean_cycle_sequencer_core.sv
// Top level of the dock clean cycle sequencer: APB registers, state and result registers.
// Depends on dcs_pkg, dcs_ifs (dcs_in_if, dcs_out_if), dcs_step and assert_macros.svh.
// The result of an accepted item is loaded into the result register.
// Throughput: one item per cycle while results are taken; the state register loops through dcs_step.
// The input holds off only while a result waits in the result register untaken.
// Reset: asynchronous, active low; phase goes to end, counters and contact bits clear,
// registers take their default values. No clearing pass; items are taken right after reset.
`default_nettype none

`include "assert_macros.svh"

module dock_clean_cycle_sequencer_core import dcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ApbAw-1:0]   paddr,
  input  wire logic [ApbDw-1:0]   pwdata,
  output logic      [ApbDw-1:0]   prdata,
  output logic                    pready,
  // item channels
  dcs_in_if.sink                  item_i,
  dcs_out_if.source               result_o
);

  cfg_t    cfg_q;
  state_t  st_q, st_d;
  result_t res_q, res_d;
  item_t   item;
  logic    res_valid_q;
  logic    in_acc;
  logic    cfg_wr;
  reg_e    reg_sel;

  // ---------------------------------------------------------------------------
  // Configuration port: zero wait states, register i at byte address 4*i.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[ApbAw-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.add_timeout_ticks     <= AddTimeoutRst;
      cfg_q.drain_timeout_ticks   <= DrainTimeoutRst;
      cfg_q.clean_ticks           <= CleanTicksRst;
      cfg_q.heartbeat_limit       <= HbLimitRst;
      cfg_q.battery_low_permille  <= BattLowRst;
      cfg_q.battery_full_permille <= BattFullRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ADD_TIMEOUT:   cfg_q.add_timeout_ticks     <= pwdata[15:0];
        REG_DRAIN_TIMEOUT: cfg_q.drain_timeout_ticks   <= pwdata[15:0];
        REG_CLEAN_TICKS:   cfg_q.clean_ticks           <= pwdata[7:0];
        REG_HB_LIMIT:      cfg_q.heartbeat_limit       <= pwdata[7:0];
        REG_BATT_LOW:      cfg_q.battery_low_permille  <= pwdata[9:0];
        REG_BATT_FULL:     cfg_q.battery_full_permille <= pwdata[9:0];
        default: begin
          // unmapped slots: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ADD_TIMEOUT:   prdata = {16'd0, cfg_q.add_timeout_ticks};
      REG_DRAIN_TIMEOUT: prdata = {16'd0, cfg_q.drain_timeout_ticks};
      REG_CLEAN_TICKS:   prdata = {24'd0, cfg_q.clean_ticks};
      REG_HB_LIMIT:      prdata = {24'd0, cfg_q.heartbeat_limit};
      REG_BATT_LOW:      prdata = {22'd0, cfg_q.battery_low_permille};
      REG_BATT_FULL:     prdata = {22'd0, cfg_q.battery_full_permille};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side: take a new item whenever the result register is empty or is
  // being drained this cycle; hold the input only while a result waits untaken.
  // ---------------------------------------------------------------------------
  assign item_i.ready = !res_valid_q || result_o.ready;
  assign in_acc       = item_i.valid && item_i.ready;

  assign item.sync_ok          = item_i.sync_ok;
  assign item.heartbeat        = item_i.heartbeat;
  assign item.electrode_down   = item_i.electrode_down;
  assign item.charging         = item_i.charging;
  assign item.charge_paused    = item_i.charge_paused;
  assign item.battery_permille = item_i.battery_permille;
  assign item.clean_water_high = item_i.clean_water_high;
  assign item.sewage_low       = item_i.sewage_low;
  assign item.tank_full        = item_i.tank_full;
  assign item.emergency        = item_i.emergency;
  assign item.service_ok       = item_i.service_ok;

  // One tick of the sequence: watchdog, contact edges, then the phase step.
  dcs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .item_i   (item),
    .state_o  (st_d),
    .result_o (res_d)
  );

  // Sequencer state: advance only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase          <= PH_END;
      st_q.add_count      <= '0;
      st_q.drain_count    <= '0;
      st_q.clean_count    <= '0;
      st_q.prev_heartbeat <= '0;
      st_q.stale_count    <= '0;
      st_q.contact_prev   <= 1'b0;
      st_q.contact_now    <= 1'b0;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // Result register: valid clears when taken, sets on a new item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_acc) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; load it with each accepted item.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid                = res_valid_q;
  assign result_o.cycle_state          = res_q.cycle_state;
  assign result_o.service_request      = res_q.service_request;
  assign result_o.valve_action         = res_q.valve_action;
  assign result_o.pause_pulse          = res_q.pause_pulse;
  assign result_o.motor_enable_pulse   = res_q.motor_enable_pulse;
  assign result_o.battery_update_pulse = res_q.battery_update_pulse;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Sequencer state must hold between accepted items.
  `DCS_ASSERT(a_state_hold, clk_i, rst_ni, !in_acc |=> $stable(st_q), "state moved without an item")
  // A contact edge always raises both pulses together.
  `DCS_ASSERT(a_edge_pulses, clk_i, rst_ni, res_valid_q |-> (res_q.motor_enable_pulse == res_q.battery_update_pulse), "motor and battery pulses differ")
  // A service request only comes out of a started or waiting phase.
  `DCS_ASSERT(a_req_phase, clk_i, rst_ni, (res_valid_q && (res_q.service_request != REQ_NONE)) |-> ((res_q.cycle_state != PH_INIT) && (res_q.cycle_state != PH_END) && (res_q.cycle_state != PH_ADD_S)), "service request from idle phase")
  // The pause pulse never comes with a cycle that fell back to init.
  `DCS_ASSERT(a_pause_phase, clk_i, rst_ni, (res_valid_q && res_q.pause_pulse) |-> (res_q.cycle_state != PH_INIT), "pause pulse in init phase")

endmodule

`default_nettype wire

### sv/dcs_step.sv
// Next-state and result logic for one tick of the clean cycle sequencer.
// Depends on dcs_pkg; purely combinational.
`default_nettype none

module dcs_step import dcs_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  always_comb begin
    state_t  st;
    result_t res;
    logic    handle;
    logic    go;
    logic    wait_charge;

    st          = state_i;
    handle      = 1'b0;
    go          = 1'b1;
    wait_charge = 1'b0;
    res.service_request      = REQ_NONE;
    res.valve_action         = VALVE_KEEP;
    res.pause_pulse          = 1'b0;
    res.motor_enable_pulse   = 1'b0;
    res.battery_update_pulse = 1'b0;

    if (item_i.sync_ok) begin
      // heartbeat watchdog, saturating
      if (state_i.prev_heartbeat == item_i.heartbeat) begin
        if (state_i.stale_count != 8'hFF) begin
          st.stale_count = state_i.stale_count + 8'd1;
        end
      end else begin
        st.stale_count = 8'd0;
      end
      st.prev_heartbeat = item_i.heartbeat;

      if (st.stale_count > cfg_i.heartbeat_limit) begin
        st.contact_prev = 1'b0;
        st.contact_now  = 1'b0;
        if (st.phase != PH_END) begin
          st.phase = PH_FAILED;
          handle   = 1'b1;
        end
      end else begin
        st.contact_prev = state_i.contact_now;
        st.contact_now  = item_i.electrode_down;
        if (item_i.electrode_down != state_i.contact_now) begin
          if (item_i.electrode_down) begin
            res.motor_enable_pulse   = 1'b1;
            res.battery_update_pulse = 1'b1;
            st.phase                 = PH_INIT;
          end else begin
            st.phase = PH_FAILED;
            handle   = 1'b1;
            go       = 1'b0;
          end
        end
        if (go && item_i.electrode_down) begin
          if ((item_i.charging || (item_i.battery_permille >= cfg_i.battery_full_permille))
              && (st.phase == PH_INIT)) begin
            if (item_i.battery_permille < cfg_i.battery_low_permille) begin
              wait_charge = 1'b1;
            end else begin
              st.phase = PH_ADD_S;
            end
          end
          if (!wait_charge) begin
            if ((st.phase >= PH_ADD_S) && (st.phase <= PH_FAILED)) begin
              res.pause_pulse = 1'b1;
            end
            if (item_i.charge_paused) begin
              handle = 1'b1;
            end
          end
        end
      end

      if (handle) begin
        case (st.phase)
          PH_ADD_S: begin
            if (item_i.clean_water_high) begin
              st.phase = PH_DRAIN_S;
            end else begin
              res.service_request = REQ_ADD_START;
              st.phase = item_i.service_ok ? PH_ADD_W : PH_FAILED;
            end
          end
          PH_ADD_W: begin
            if (st.add_count != 16'hFFFF) begin
              st.add_count = st.add_count + 16'd1;
            end
            if (item_i.clean_water_high || (st.add_count >= cfg_i.add_timeout_ticks)) begin
              st.add_count        = 16'd0;
              res.service_request = REQ_ADD_STOP;
              st.phase = item_i.service_ok ? PH_DRAIN_S : PH_FAILED;
            end
          end
          PH_DRAIN_S: begin
            if (item_i.sewage_low) begin
              st.phase = PH_CLEAN_S;
            end else begin
              res.service_request = REQ_DRAIN_START;
              st.phase = item_i.service_ok ? PH_DRAIN_W : PH_FAILED;
            end
          end
          PH_DRAIN_W: begin
            if (st.drain_count != 16'hFFFF) begin
              st.drain_count = st.drain_count + 16'd1;
            end
            if (item_i.sewage_low || (st.drain_count >= cfg_i.drain_timeout_ticks)) begin
              st.drain_count      = 16'd0;
              res.valve_action    = VALVE_CLOSE;
              res.service_request = REQ_DRAIN_STOP;
              st.phase = item_i.service_ok ? PH_CLEAN_S : PH_FAILED;
            end else begin
              res.valve_action = (item_i.tank_full || item_i.emergency) ? VALVE_CLOSE
                                                                         : VALVE_OPEN;
            end
          end
          PH_CLEAN_S: begin
            res.service_request = REQ_CLEAN_START;
            st.phase = item_i.service_ok ? PH_CLEAN_W : PH_FAILED;
          end
          PH_CLEAN_W: begin
            if (st.clean_count != 8'hFF) begin
              st.clean_count = st.clean_count + 8'd1;
            end
            if (st.clean_count > cfg_i.clean_ticks) begin
              res.service_request = REQ_CLEAN_STOP;
              st.phase       = item_i.service_ok ? PH_FINISH : PH_FAILED;
              st.clean_count = 8'd0;
            end
          end
          PH_FINISH: begin
            st.phase = PH_END;
          end
          PH_FAILED: begin
            st.add_count     = 16'd0;
            st.drain_count   = 16'd0;
            st.clean_count   = 8'd0;
            res.valve_action = VALVE_CLOSE;
            st.phase         = PH_END;
          end
          default: begin
          end
        endcase
      end
    end

    res.cycle_state = st.phase;
    state_o  = st;
    result_o = res;
  end

endmodule

`default_nettype wire
